// File: src/qscd_pkg.sv
package qscd_pkg;

  // grid and number format
  localparam int MAX_CELLS = 1024;
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int FRAC_BITS = 16;
  localparam int ACC_WIDTH = 40;
  localparam int POS_W     = 27;
  localparam int IPART_W   = POS_W - FRAC_BITS;
  localparam int D_W       = FRAC_BITS + 1;
  localparam int W_W       = FRAC_BITS + 2;

  // configuration register widths
  localparam int NCELL_W = 11;
  localparam int RULE_W  = 2;

  // configuration register indexes
  localparam logic [1:0] REG_CELLS = 2'd0;
  localparam logic [1:0] REG_LEFT  = 2'd1;
  localparam logic [1:0] REG_RIGHT = 2'd2;

  // wall rules
  localparam logic [RULE_W-1:0] RULE_DROP = 2'd0;
  localparam logic [RULE_W-1:0] RULE_SUB  = 2'd1;
  localparam logic [RULE_W-1:0] RULE_FOLD = 2'd2;
  localparam logic [RULE_W-1:0] RULE_WRAP = 2'd3;

  // input opcodes
  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic [D_W-1:0] ONE = D_W'(1) << FRAC_BITS;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;
  typedef logic signed [W_W-1:0]       weight_t;

  // single port memory request
  typedef struct packed {
    logic              en;
    logic              we;
    logic [CELL_W-1:0] addr;
    acc_t              wdata;
  } mem_req_t;

endpackage

// File: src/qscd_if.sv
interface qscd_in_if import qscd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [POS_W-1:0]   particle_position;
  logic [CELL_W-1:0]  read_cell;

  modport source (output valid, opcode, particle_position, read_cell, input ready);
  modport sink   (input valid, opcode, particle_position, read_cell, output ready);
endinterface

interface qscd_out_if import qscd_pkg::*; ();
  logic              valid;
  logic              ready;
  acc_t              cell_charge;
  logic [CELL_W-1:0] cell_number;

  modport source (output valid, cell_charge, cell_number, input ready);
  modport sink   (input valid, cell_charge, cell_number, output ready);
endinterface

// File: src/qscd_charge_mem.sv
module qscd_charge_mem import qscd_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output acc_t     rdata
);

  acc_t mem [MAX_CELLS];
  acc_t rdata_r;

  // read data only moves on a read, so it holds while the block waits
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata_r <= mem[req.addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/qscd_sq_round.sv
module qscd_sq_round import qscd_pkg::*; (
  input  logic [D_W-1:0]       x,
  output logic [FRAC_BITS-1:0] w
);

  logic [2*D_W-1:0] prod;
  logic [2*D_W-1:0] rnd;

  // round(x*x/2) at FRAC_BITS fraction bits, half up
  always_comb begin
    prod = x * x;
    rnd  = prod + ((2*D_W)'(1) << FRAC_BITS);
    w    = rnd[2*FRAC_BITS:FRAC_BITS+1];
  end

endmodule

// File: src/qscd_sat_add.sv
module qscd_sat_add import qscd_pkg::*; (
  input  acc_t    a,
  input  weight_t w,
  output acc_t    y
);

  localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH:0] sum;

  always_comb begin
    sum = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(w);
    if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
      y = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      y = sum[ACC_WIDTH-1:0];
    end
  end

endmodule

// File: src/quadratic_spline_charge_deposit.sv
// deposit: ready again once done; the two weight squares take turns on the shared multiplier,
// then each charge update (read, add and write back) runs on the single port store, and a
// share that a drop wall throws away is skipped without a write; no result
// read: once the result register is free the result is registered, the cell is cleared, then ready again
// reset (synchronous, rst_n low): registers to 1024 cells and drop walls, then a clearing
// pass zeroes all 1024 cells of the charge store while no transaction is taken
module quadratic_spline_charge_deposit import qscd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  qscd_in_if.sink           in_ch,
  qscd_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // sequencer states
  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MUL_R  = 3'd2;
  localparam logic [2:0] S_MUL_L  = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_WR     = 3'd5;
  localparam logic [2:0] S_RC_RD  = 3'd6;
  localparam logic [2:0] S_RC_OUT = 3'd7;

  // update slots of one deposit: centre, left share, right share
  localparam logic [1:0] OP_CENTRE = 2'd0;
  localparam logic [1:0] OP_LEFT   = 2'd1;
  localparam logic [1:0] OP_RIGHT  = 2'd2;

  // configuration registers
  logic [NCELL_W-1:0] cells_r;
  logic [RULE_W-1:0]  lrule_r;
  logic [RULE_W-1:0]  rrule_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  // sequencer and datapath registers
  logic [2:0]           state_r, state_nxt;
  logic [CELL_W-1:0]    clr_cnt_r;
  logic [CELL_W-1:0]    cell_r, cell_nxt;
  logic [D_W-1:0]       d_r, d_nxt;
  logic [FRAC_BITS-1:0] wr_r, wl_r;
  logic [1:0]           op_idx_r, op_idx_nxt;
  logic [CELL_W-1:0]    op_addr_r;
  weight_t              op_w_r;
  logic                 out_valid_r;
  acc_t                 out_charge_r;
  logic [CELL_W-1:0]    out_cell_r;

  // effective cell count and last cell
  logic [NCELL_W-1:0] n_eff;
  logic [CELL_W-1:0]  n_last;

  // cell and offset of an incoming position
  logic [IPART_W-1:0] cell_raw;
  logic [POS_W-1:0]   clamp_off;

  // shared multiplier
  logic [D_W-1:0]       sq_in;
  logic [FRAC_BITS-1:0] sq_w;

  // update plan for the current slot
  logic              plan_en;
  logic [CELL_W-1:0] plan_addr;
  weight_t           plan_w;
  weight_t           wl_s, wr_s, wc_s;

  // store and adder
  mem_req_t mem_req;
  acc_t     mem_rdata;
  acc_t     sum;
  logic     in_acc;
  logic     out_free;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= NCELL_W'(MAX_CELLS);
      lrule_r <= RULE_DROP;
      rrule_r <= RULE_DROP;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CELLS: cells_r <= cfg_pwdata[NCELL_W-1:0];
        REG_LEFT:  lrule_r <= cfg_pwdata[RULE_W-1:0];
        REG_RIGHT: rrule_r <= cfg_pwdata[RULE_W-1:0];
        default: ;  // unmapped register, write ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CELLS: cfg_prdata = 32'(cells_r);
      REG_LEFT:  cfg_prdata = 32'(lrule_r);
      REG_RIGHT: cfg_prdata = 32'(rrule_r);
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // a count of zero behaves as one, anything above the store size as the store size
  always_comb begin
    priority if (cells_r == '0) begin
      n_eff = NCELL_W'(1);
    end else if (cells_r > NCELL_W'(MAX_CELLS)) begin
      n_eff = NCELL_W'(MAX_CELLS);
    end else begin
      n_eff = cells_r;
    end
    n_last = CELL_W'(n_eff - NCELL_W'(1));
  end

  // ---------------------------------------------------------------------------
  // position split: a cell past the grid clamps to the last cell and the
  // offset saturates at one, so it sits on the right wall
  // ---------------------------------------------------------------------------
  assign cell_raw  = in_ch.particle_position[POS_W-1:FRAC_BITS];
  assign clamp_off = in_ch.particle_position - POS_W'({n_last, {FRAC_BITS{1'b0}}});

  always_comb begin
    if (IPART_W'(cell_raw) >= IPART_W'(n_eff)) begin
      cell_nxt = n_last;
      d_nxt    = (clamp_off > POS_W'(ONE)) ? ONE : clamp_off[D_W-1:0];
    end else begin
      cell_nxt = cell_raw[CELL_W-1:0];
      d_nxt    = D_W'(in_ch.particle_position[FRAC_BITS-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // shared square-and-round unit: right weight from d, then left weight from 1-d
  // ---------------------------------------------------------------------------
  assign sq_in = (state_r == S_MUL_L) ? (ONE - d_r) : d_r;

  qscd_sq_round u_sq (
    .x (sq_in),
    .w (sq_w)
  );

  // ---------------------------------------------------------------------------
  // update plan: centre first, then left share, then right share; a share past
  // a wall follows that wall's rule
  // ---------------------------------------------------------------------------
  assign wl_s = $signed({2'b00, wl_r});
  assign wr_s = $signed({2'b00, wr_r});
  assign wc_s = $signed(W_W'(ONE)) - wl_s - wr_s;

  always_comb begin
    plan_en   = 1'b1;
    plan_addr = cell_r;
    plan_w    = wc_s;
    unique case (op_idx_r)
      OP_CENTRE: begin
        plan_addr = cell_r;
        plan_w    = wc_s;
      end
      OP_LEFT: begin
        if (cell_r != '0) begin
          plan_addr = cell_r - CELL_W'(1);
          plan_w    = wl_s;
        end else begin
          unique case (lrule_r)
            RULE_DROP: plan_en = 1'b0;
            RULE_SUB: begin
              plan_addr = '0;
              plan_w    = -wl_s;
            end
            RULE_FOLD: begin
              plan_addr = '0;
              plan_w    = wl_s;
            end
            RULE_WRAP: begin
              plan_addr = n_last;
              plan_w    = wl_s;
            end
            default: plan_en = 1'b0;
          endcase
        end
      end
      OP_RIGHT: begin
        if (cell_r != n_last) begin
          plan_addr = cell_r + CELL_W'(1);
          plan_w    = wr_s;
        end else begin
          unique case (rrule_r)
            RULE_DROP: plan_en = 1'b0;
            RULE_SUB: begin
              plan_addr = n_last;
              plan_w    = -wr_s;
            end
            RULE_FOLD: begin
              plan_addr = n_last;
              plan_w    = wr_s;
            end
            RULE_WRAP: begin
              plan_addr = '0;
              plan_w    = wr_s;
            end
            default: plan_en = 1'b0;
          endcase
        end
      end
      default: plan_en = 1'b0;
    endcase
  end

  // shared saturating adder on the store read data
  qscd_sat_add u_add (
    .a (mem_rdata),
    .w (op_w_r),
    .y (sum)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    op_idx_nxt = op_idx_r;
    mem_req    = '{en: 1'b0, we: 1'b0, addr: cell_r, wdata: '0};
    unique case (state_r)
      S_CLR: begin
        mem_req = '{en: 1'b1, we: 1'b1, addr: clr_cnt_r, wdata: '0};
        if (clr_cnt_r == CELL_W'(MAX_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt  = (in_ch.opcode == OP_READ) ? S_RC_RD : S_MUL_R;
          op_idx_nxt = OP_CENTRE;
        end
      end
      S_MUL_R: state_nxt = S_MUL_L;
      S_MUL_L: state_nxt = S_RD;
      S_RD: begin
        if (plan_en) begin
          mem_req   = '{en: 1'b1, we: 1'b0, addr: plan_addr, wdata: '0};
          state_nxt = S_WR;
        end else if (op_idx_r == OP_RIGHT) begin
          state_nxt = S_IDLE;
        end else begin
          op_idx_nxt = op_idx_r + 2'd1;
        end
      end
      S_WR: begin
        mem_req = '{en: 1'b1, we: 1'b1, addr: op_addr_r, wdata: sum};
        if (op_idx_r == OP_RIGHT) begin
          state_nxt = S_IDLE;
        end else begin
          op_idx_nxt = op_idx_r + 2'd1;
          state_nxt  = S_RD;
        end
      end
      S_RC_RD: begin
        mem_req   = '{en: 1'b1, we: 1'b0, addr: cell_r, wdata: '0};
        state_nxt = S_RC_OUT;
      end
      S_RC_OUT: begin
        // wait for the result register, then clear the cell that was read
        if (out_free) begin
          mem_req   = '{en: 1'b1, we: 1'b1, addr: cell_r, wdata: '0};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      op_idx_r    <= OP_CENTRE;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      op_idx_r <= op_idx_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + CELL_W'(1);
      end
      if (state_r == S_RC_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cell_r <= (in_ch.opcode == OP_READ) ? in_ch.read_cell : cell_nxt;
      d_r    <= d_nxt;
    end
    if (state_r == S_MUL_R) begin
      wr_r <= sq_w;
    end
    if (state_r == S_MUL_L) begin
      wl_r <= sq_w;
    end
    if (state_r == S_RD) begin
      op_addr_r <= plan_addr;
      op_w_r    <= plan_w;
    end
    if (state_r == S_RC_OUT && out_free) begin
      out_charge_r <= mem_rdata;
      out_cell_r   <= cell_r;
    end
  end

  qscd_charge_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cell_charge = out_charge_r;
  assign out_ch.cell_number = out_cell_r;

endmodule

// File: sim/charge_deposit_checker.sv
`timescale 1ns / 100ps

module charge_deposit_checker import qscd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  qscd_in_if          in_ch,
  qscd_out_if         out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatch_count,
  output int          reports_pending
);

  localparam longint UNIT       = longint'(1) << FRAC_BITS;
  localparam longint ACC_TOP    = (longint'(1) << (ACC_WIDTH - 1)) - 1;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;
  localparam int     PRINT_CAP  = 200;

  typedef struct packed {
    acc_t              cell_charge;
    logic [CELL_W-1:0] cell_number;
  } cell_report_t;

  acc_t               charge_model [MAX_CELLS];
  logic [NCELL_W-1:0] grid_cells;
  logic [RULE_W-1:0]  left_rule;
  logic [RULE_W-1:0]  right_rule;
  cell_report_t       reports_due [$];

  initial mismatch_count = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns  %s", $time, what);
    end
    mismatch_count++;
  endtask

  // saturating accumulate into one cell
  function automatic void add_charge(input longint cell_idx, input longint w);
    longint sum;
    sum = longint'(charge_model[cell_idx]) + w;
    if (sum > ACC_TOP) begin
      sum = ACC_TOP;
    end else if (sum < ACC_BOTTOM) begin
      sum = ACC_BOTTOM;
    end
    charge_model[cell_idx] = acc_t'(sum);
  endfunction

  function automatic void wall_share(input logic [RULE_W-1:0] rule, input longint wall_cell,
                                     input longint far_cell, input longint w);
    case (rule)
      RULE_SUB:  add_charge(wall_cell, -w);
      RULE_FOLD: add_charge(wall_cell, w);
      RULE_WRAP: add_charge(far_cell, w);
      default: ;
    endcase
  endfunction

  function automatic void deposit_particle(input longint pos);
    longint n;
    longint cell_idx;
    longint d;
    longint e;
    longint w_left;
    longint w_right;
    n = grid_cells;
    if (n < 1) n = 1;
    if (n > MAX_CELLS) n = MAX_CELLS;
    cell_idx = pos >> FRAC_BITS;
    if (cell_idx >= n) cell_idx = n - 1;
    d = pos - cell_idx * UNIT;
    if (d > UNIT) d = UNIT;
    e = UNIT - d;
    // half-up rounding of the squared offsets over two
    w_right = (d * d + UNIT) >> (FRAC_BITS + 1);
    w_left  = (e * e + UNIT) >> (FRAC_BITS + 1);
    add_charge(cell_idx, UNIT - w_left - w_right);
    if (cell_idx > 0) begin
      add_charge(cell_idx - 1, w_left);
    end else begin
      wall_share(left_rule, 0, n - 1, w_left);
    end
    if (cell_idx < n - 1) begin
      add_charge(cell_idx + 1, w_right);
    end else begin
      wall_share(right_rule, n - 1, 0, w_right);
    end
  endfunction

  always @(posedge clk) begin
    cell_report_t due;
    if (!rst_n) begin
      grid_cells = NCELL_W'(MAX_CELLS);
      left_rule  = RULE_DROP;
      right_rule = RULE_DROP;
      foreach (charge_model[i]) charge_model[i] = '0;
      reports_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          {REG_CELLS, 2'b00}: grid_cells = cfg_pwdata[NCELL_W-1:0];
          {REG_LEFT, 2'b00}:  left_rule  = cfg_pwdata[RULE_W-1:0];
          {REG_RIGHT, 2'b00}: right_rule = cfg_pwdata[RULE_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (reports_due.size() == 0) begin
          report_mismatch($sformatf("result for cell %0d with nothing outstanding",
                                    out_ch.cell_number));
        end else begin
          due = reports_due.pop_front();
          if (out_ch.cell_number !== due.cell_number) begin
            report_mismatch($sformatf("cell_number %0d, wanted %0d",
                                      out_ch.cell_number, due.cell_number));
          end
          if (out_ch.cell_charge !== due.cell_charge) begin
            report_mismatch($sformatf("cell %0d: cell_charge %0d, wanted %0d",
                                      due.cell_number, out_ch.cell_charge, due.cell_charge));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_DEPOSIT) begin
          deposit_particle(longint'(in_ch.particle_position));
        end else begin
          due.cell_charge = charge_model[in_ch.read_cell];
          due.cell_number = in_ch.read_cell;
          charge_model[in_ch.read_cell] = '0;
          reports_due.push_back(due);
        end
      end
    end
    reports_pending = reports_due.size();
  end

endmodule

// File: sim/tb_quadratic_spline_charge_deposit.sv
`timescale 1ns / 100ps

module tb_quadratic_spline_charge_deposit;
  import qscd_pkg::*;

  // index with no register behind it, writes there must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int SETTLE_CYCLES   = 24;   // longest deposit plus margin
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off to back the block up
  localparam int ITEMS_PER_PHASE = 155;
  localparam int PHASES          = 10;

  // register settings per phase, extremes and out-of-range cell counts included
  int unsigned       phase_cells [PHASES] = '{4, 1, 1, 2, 0, 2047, 1025, 16, 7, 1024};
  logic [RULE_W-1:0] phase_left  [PHASES] = '{RULE_SUB, RULE_WRAP, RULE_SUB, RULE_FOLD,
                                              RULE_WRAP, RULE_SUB, RULE_FOLD, RULE_WRAP,
                                              RULE_DROP, RULE_FOLD};
  logic [RULE_W-1:0] phase_right [PHASES] = '{RULE_FOLD, RULE_WRAP, RULE_FOLD, RULE_WRAP,
                                              RULE_SUB, RULE_WRAP, RULE_DROP, RULE_WRAP,
                                              RULE_SUB, RULE_FOLD};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int   mismatch_count;
  int   reports_pending;
  bit   quiet   = 1'b0;  // no idling on either side while set
  bit   hold_go = 1'b0;  // starts the long receiver hold-off
  logic hold_off = 1'b0;

  qscd_in_if  in_ch ();
  qscd_out_if out_ch ();

  quadratic_spline_charge_deposit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  charge_deposit_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // offer one transaction after a random gap, return once it is taken
  task automatic send_item(input logic op, input logic [POS_W-1:0] pos,
                           input logic [CELL_W-1:0] cell_idx);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.opcode            <= op;
    in_ch.particle_position <= pos;
    in_ch.read_cell         <= cell_idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // setup phase, access phase, then an idle phase so back-to-back writes never
  // lower and raise psel in the same step
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every outstanding read result, then let a trailing deposit finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    wait (reports_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random transaction shaped around the live grid of n cells
  task automatic send_random_item(input int n);
    int                pick;
    int                frac;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_idx;
    if ($urandom_range(0, 3) == 0) begin
      // reads mostly land on the live grid or just past it, sometimes anywhere in the store
      if ($urandom_range(0, 4) != 0) begin
        cell_idx = CELL_W'($urandom_range(0, (n < MAX_CELLS) ? n : MAX_CELLS - 1));
      end else begin
        cell_idx = CELL_W'($urandom);
      end
      send_item(OP_READ, POS_W'($urandom), cell_idx);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        // anywhere on the grid and a little past the right wall
        pos = POS_W'($urandom_range(0, (n + 1) << FRAC_BITS));
      end else if (pick == 7) begin
        // offset on a corner: zero, one ulp, a half, just below one
        case ($urandom_range(0, 3))
          0:       frac = 0;
          1:       frac = 1;
          2:       frac = 1 << (FRAC_BITS - 1);
          default: frac = (1 << FRAC_BITS) - 1;
        endcase
        pos = POS_W'(($urandom_range(0, n - 1) << FRAC_BITS) | frac);
      end else if (pick == 8) begin
        // whole field, often far past the grid
        pos = POS_W'($urandom);
      end else begin
        // exactly on the left or the right wall
        pos = $urandom_range(0, 1) ? POS_W'(n << FRAC_BITS) : '0;
      end
      send_item(OP_DEPOSIT, pos, CELL_W'($urandom));
    end
  endtask

  // receiver: random stall before each transaction, long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 4);
        repeat (stall) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      end
    end
  end

  // long hold-off, counted on its own while the sender keeps offering
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // hard limit, well above the slowest legal run including the clearing pass
  initial begin
    #(3_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int n;
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.opcode            <= OP_DEPOSIT;
    in_ch.particle_position <= '0;
    in_ch.read_cell         <= '0;
    cfg_psel                <= 1'b0;
    cfg_penable             <= 1'b0;
    cfg_pwrite              <= 1'b0;
    cfg_paddr               <= '0;
    cfg_pwdata              <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on the reset grid of 1024 cells with drop walls;
    // the clearing pass holds the first transaction off until it is done
    send_item(OP_DEPOSIT, 27'h000_0000, '0);  // on the left wall, left share dropped
    send_item(OP_DEPOSIT, 27'h000_8000, '0);  // half offset in the first cell
    send_item(OP_DEPOSIT, 27'h001_8000, '0);
    send_item(OP_DEPOSIT, 27'h002_FFFF, '0);  // offset just below one
    send_item(OP_DEPOSIT, 27'h003_0001, '0);  // offset of one ulp
    send_item(OP_DEPOSIT, 27'h3FF_0000, '0);  // last cell
    send_item(OP_DEPOSIT, 27'h3FF_FFFF, '0);
    send_item(OP_DEPOSIT, 27'h400_0000, '0);  // on the right wall, clamped into the last cell
    send_item(OP_DEPOSIT, 27'h7FF_FFFF, '0);  // largest position, clamped and offset saturated
    send_item(OP_DEPOSIT, 27'h155_5555, '0);
    send_item(OP_DEPOSIT, 27'h2AA_AAAA, '0);
    send_item(OP_READ, 27'h7FF_FFFF, 10'd0);
    send_item(OP_READ, '0, 10'd1);
    send_item(OP_READ, '0, 10'd2);
    send_item(OP_READ, '0, 10'd3);
    send_item(OP_READ, '0, 10'd4);
    send_item(OP_READ, '0, 10'd1022);
    send_item(OP_READ, '0, 10'd1023);
    send_item(OP_READ, '0, 10'd1023);         // read again after clearing
    send_item(OP_READ, '0, 10'd512);          // never touched
    send_item(OP_READ, '0, 10'h155);
    send_item(OP_READ, '0, 10'h2AA);
    send_item(OP_READ, '0, 10'h2AB);
    settle();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == 3) || (p == 7);
      write_register(REG_CELLS, phase_cells[p]);
      write_register(REG_LEFT, 32'(phase_left[p]));
      write_register(REG_RIGHT, 32'(phase_right[p]));
      if (p == 5) begin
        write_register(REG_SPARE, 32'd5);
      end
      // a count of zero acts as one cell, anything above the store as the full store
      n = phase_cells[p];
      if (n < 1) n = 1;
      if (n > MAX_CELLS) n = MAX_CELLS;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 2 && k == 40) begin
          hold_go = 1'b1;
        end
        send_random_item(n);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
